FILE: sv/triangle_unit_normal_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle unit normal block
// Shared concurrent assertion forms, clocked on clk_i with reset disable.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_MACROS_SVH

// Same-cycle implication.
`define TUN_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define TUN_ASSERT_DLY(lbl, ant, n, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> ##n (con)) \
    else $error(msg);

`endif

FILE: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Transaction types and pipeline constants shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tun_pkg;

  localparam int unsigned CoordW     = 24;
  localparam int unsigned NormW      = 31;
  localparam int unsigned SumW       = 64;
  localparam int unsigned RootW      = 32;
  localparam int unsigned QuotW      = 16;
  localparam int unsigned SqrtStages = 16;
  localparam int unsigned DivStages  = 8;
  // Input, edge, product, cross, nibble, position, shift, square, sum.
  localparam int unsigned PreStages  = 9;
  localparam int unsigned Latency    = PreStages + SqrtStages + DivStages + 1;

  // One input transaction: three vertices in Q12.12.
  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } tun_in_t;

  // One result transaction: Q1.15 unit normal and degenerate flag.
  typedef struct packed {
    logic signed [QuotW-1:0] normal_x;
    logic signed [QuotW-1:0] normal_y;
    logic signed [QuotW-1:0] normal_z;
    logic                    degenerate;
  } tun_out_t;

  // Per-triangle data carried alongside the square root and divider.
  typedef struct packed {
    logic [2:0][NormW-1:0] mag;
    logic [2:0]            neg;
    logic                  degen;
  } tun_lane_t;

endpackage

FILE: sv/triangle_unit_normal_unit.sv
// Throughput: one triangle per cycle; busy_o is always low, nothing stalls.
// The pipeline holds 34 registers: nine front stages, sixteen
// square-root stages, eight divider stages and the output register.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges, scaled to a Q1.15 unit vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_unit_normal_unit_macros.svh"

module triangle_unit_normal_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tun_pkg::tun_in_t  tri_i,
  output logic              done_o,
  output tun_pkg::tun_out_t norm_o
);
  import tun_pkg::*;

  localparam int unsigned MagW = 51;
  localparam int unsigned Nibs = 13;

  function automatic logic [1:0] nib_lz(logic [3:0] n);
    logic [1:0] r;
    if (n[3]) r = 2'd0;
    else if (n[2]) r = 2'd1;
    else if (n[1]) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  logic [PreStages-1:0] v_q;
  tun_in_t              in_q;
  logic signed [24:0]   e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [49:0]   prod_q [6];
  logic [2:0][MagW-1:0] mag_q, mag4_q, mag5_q;
  logic [2:0]           neg3_q, neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic [Nibs-1:0]      nz_q;
  logic [Nibs-1:0][1:0] lzn_q;
  logic [5:0]           pos_q;
  logic                 dg5_q, dg6_q, dg7_q, dg8_q;
  logic [2:0][NormW-1:0] nm6_q, nm7_q, nm8_q;
  logic [61:0]          sq_q [3];
  logic [SumW-1:0]      sum_q;
  logic [4*Nibs-1:0]    orw;
  logic [5:0]           pos_d;
  logic                 dg_d;
  logic [2:0][NormW-1:0] nm_d;
  logic signed [50:0]   cx, cy, cz;
  logic                 sq_v, dv_v;
  logic [31:0]          root;
  tun_lane_t            lane_s, lane_sq, lane_dv;
  logic [2:0][QuotW-1:0] quot;
  logic                 done_q;
  tun_out_t             out_q, out_d;

  // The pipeline never holds off a transaction.
  assign busy_o = 1'b0;

  // Cross product components from the registered products.
  assign cx = {prod_q[0][49], prod_q[0]} - {prod_q[1][49], prod_q[1]};
  assign cy = {prod_q[2][49], prod_q[2]} - {prod_q[3][49], prod_q[3]};
  assign cz = {prod_q[4][49], prod_q[4]} - {prod_q[5][49], prod_q[5]};

  assign orw = {1'b0, mag_q[0] | mag_q[1] | mag_q[2]};

  // Leading one position over the nibble flags; highest nonzero nibble wins.
  always_comb begin
    pos_d = '0;
    for (int j = 0; j < Nibs; j++) begin
      if (nz_q[j]) pos_d = 6'(4 * j) + {4'b0000, ~lzn_q[j]};
    end
    dg_d = ~|nz_q;
  end

  // Common shift that puts the largest magnitude into [2^30, 2^31).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_q >= 6'd30) begin
        nm_d[i] = NormW'(mag5_q[i] >> 5'(pos_q - 6'd30));
      end else begin
        nm_d[i] = NormW'(mag5_q[i] << 5'(6'd30 - pos_q));
      end
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PreStages-2:0], start_i & ~busy_o};
    end
  end

  // Front stages: input, edges, products, cross, leading one search, shift, squares, sum.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= tri_i;
    end
    e1x_q <= {in_q.b_x[23], in_q.b_x} - {in_q.a_x[23], in_q.a_x};
    e1y_q <= {in_q.b_y[23], in_q.b_y} - {in_q.a_y[23], in_q.a_y};
    e1z_q <= {in_q.b_z[23], in_q.b_z} - {in_q.a_z[23], in_q.a_z};
    e2x_q <= {in_q.c_x[23], in_q.c_x} - {in_q.a_x[23], in_q.a_x};
    e2y_q <= {in_q.c_y[23], in_q.c_y} - {in_q.a_y[23], in_q.a_y};
    e2z_q <= {in_q.c_z[23], in_q.c_z} - {in_q.a_z[23], in_q.a_z};
    prod_q[0] <= e1y_q * e2z_q;
    prod_q[1] <= e1z_q * e2y_q;
    prod_q[2] <= e1z_q * e2x_q;
    prod_q[3] <= e1x_q * e2z_q;
    prod_q[4] <= e1x_q * e2y_q;
    prod_q[5] <= e1y_q * e2x_q;
    mag_q[0] <= cx[50] ? MagW'(-cx) : MagW'(cx);
    mag_q[1] <= cy[50] ? MagW'(-cy) : MagW'(cy);
    mag_q[2] <= cz[50] ? MagW'(-cz) : MagW'(cz);
    neg3_q   <= {cz[50], cy[50], cx[50]};
    for (int j = 0; j < Nibs; j++) begin
      nz_q[j]  <= |orw[4*j +: 4];
      lzn_q[j] <= nib_lz(orw[4*j +: 4]);
    end
    mag4_q <= mag_q;
    neg4_q <= neg3_q;
    pos_q  <= pos_d;
    dg5_q  <= dg_d;
    mag5_q <= mag4_q;
    neg5_q <= neg4_q;
    nm6_q  <= nm_d;
    dg6_q  <= dg5_q;
    neg6_q <= neg5_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= nm6_q[i] * nm6_q[i];
    end
    nm7_q  <= nm6_q;
    dg7_q  <= dg6_q;
    neg7_q <= neg6_q;
    sum_q  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    nm8_q  <= nm7_q;
    dg8_q  <= dg7_q;
    neg8_q <= neg7_q;
  end

  assign lane_s.mag   = nm8_q;
  assign lane_s.neg   = neg8_q;
  assign lane_s.degen = dg8_q;

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[PreStages-1]),
    .s_i     (sum_q),
    .lane_i  (lane_s),
    .valid_o (sq_v),
    .root_o  (root),
    .lane_o  (lane_sq)
  );

  tun_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .root_i  (root),
    .lane_i  (lane_sq),
    .valid_o (dv_v),
    .quot_o  (quot),
    .lane_o  (lane_dv)
  );

  // Saturation to 32767, sign, and the degenerate override.
  always_comb begin
    logic [2:0][QuotW-1:0] val;
    for (int i = 0; i < 3; i++) begin
      val[i] = quot[i][QuotW-1] ? 16'd32767 : quot[i];
      if (lane_dv.neg[i]) val[i] = QuotW'(-val[i]);
      if (lane_dv.degen) val[i] = '0;
    end
    out_d.normal_x   = val[0];
    out_d.normal_y   = val[1];
    out_d.normal_z   = val[2];
    out_d.degenerate = lane_dv.degen;
  end

  // Output register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign norm_o = out_q;

  // Checks on the pipeline and the result coding.
  `TUN_ASSERT_DLY(a_latency, start_i && !busy_o, Latency, done_o, "result strobe missing")
  `TUN_ASSERT_IMP(a_degen_zero, done_o && norm_o.degenerate, norm_o.normal_x == 16'sd0 && norm_o.normal_y == 16'sd0 && norm_o.normal_z == 16'sd0, "degenerate result not zero")
  `TUN_ASSERT_IMP(a_no_min, done_o, norm_o.normal_x != 16'h8000 && norm_o.normal_y != 16'h8000 && norm_o.normal_z != 16'h8000, "component reached -1.0")

endmodule

FILE: sv/tun_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [63:0]         s_i,
  input  tun_pkg::tun_lane_t  lane_i,
  output logic                valid_o,
  output logic [31:0]         root_o,
  output tun_pkg::tun_lane_t  lane_o
);
  import tun_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic [SqrtStages-1:0] valid_q;
  logic [RemW-1:0]       rem_q  [SqrtStages];
  logic [RemW-1:0]       rem_d  [SqrtStages];
  logic [RootW-1:0]      root_q [SqrtStages];
  logic [RootW-1:0]      root_d [SqrtStages];
  logic [SumW-1:0]       s_q    [SqrtStages];
  logic [SumW-1:0]       s_d    [SqrtStages];
  tun_lane_t             lane_q [SqrtStages];

  // Each stage retires two radicand bit pairs.
  always_comb begin
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [SumW-1:0]  sv;
    logic [RemW+1:0]  acc;
    logic [RemW+1:0]  trial;
    for (int k = 0; k < SqrtStages; k++) begin
      if (k == 0) begin
        rem  = '0;
        root = '0;
        sv   = s_i;
      end else begin
        rem  = rem_q[k-1];
        root = root_q[k-1];
        sv   = s_q[k-1];
      end
      for (int j = 0; j < 2; j++) begin
        acc   = {rem, sv[SumW-1 -: 2]};
        trial = {2'b00, root, 2'b01};
        sv    = {sv[SumW-3:0], 2'b00};
        if (acc >= trial) begin
          rem  = RemW'(acc - trial);
          root = {root[RootW-2:0], 1'b1};
        end else begin
          rem  = acc[RemW-1:0];
          root = {root[RootW-2:0], 1'b0};
        end
      end
      rem_d[k]  = rem;
      root_d[k] = root;
      s_d[k]    = sv;
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SqrtStages-2:0], valid_i};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SqrtStages; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      s_q[k]    <= s_d[k];
      lane_q[k] <= (k == 0) ? lane_i : lane_q[k-1];
    end
  end

  assign valid_o = valid_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];
  assign lane_o  = lane_q[SqrtStages-1];

endmodule

FILE: sv/tun_div.sv
// ----------------------------------------------------------------------------
// Pipelined normalizing divider
// Rounded quotient of each magnitude by the length, two bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [31:0]                    root_i,
  input  tun_pkg::tun_lane_t             lane_i,
  output logic                           valid_o,
  output logic [2:0][15:0]               quot_o,
  output tun_pkg::tun_lane_t             lane_o
);
  import tun_pkg::*;

  localparam int unsigned NumW = NormW + QuotW + 1;

  logic [DivStages-1:0]   valid_q;
  logic [2:0][NumW-1:0]   rem_q  [DivStages];
  logic [2:0][NumW-1:0]   rem_d  [DivStages];
  logic [2:0][QuotW-1:0]  quot_q [DivStages];
  logic [2:0][QuotW-1:0]  quot_d [DivStages];
  logic [RootW-1:0]       root_q [DivStages];
  tun_lane_t              lane_q [DivStages];

  // Restoring division of (m * 2^16 + L) by 2L, quotient bits from the top.
  always_comb begin
    logic [NumW-1:0]  rem;
    logic [QuotW-1:0] quot;
    logic [RootW-1:0] root;
    logic [NumW:0]    sh;
    int unsigned      b;
    for (int k = 0; k < DivStages; k++) begin
      root = (k == 0) ? root_i : root_q[k-1];
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          rem  = {1'b0, lane_i.mag[i], {QuotW{1'b0}}} + NumW'(root_i);
          quot = '0;
        end else begin
          rem  = rem_q[k-1][i];
          quot = quot_q[k-1][i];
        end
        for (int j = 0; j < 2; j++) begin
          b  = QuotW - 1 - 2 * k - j;
          sh = (NumW + 1)'({root, 1'b0}) << b;
          if ({1'b0, rem} >= sh) begin
            rem  = NumW'({1'b0, rem} - sh);
            quot = {quot[QuotW-2:0], 1'b1};
          end else begin
            quot = {quot[QuotW-2:0], 1'b0};
          end
        end
        rem_d[k][i]  = rem;
        quot_d[k][i] = quot;
      end
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DivStages-2:0], valid_i};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      rem_q[k]  <= rem_d[k];
      quot_q[k] <= quot_d[k];
      root_q[k] <= (k == 0) ? root_i : root_q[k-1];
      lane_q[k] <= (k == 0) ? lane_i : lane_q[k-1];
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign quot_o  = quot_q[DivStages-1];
  assign lane_o  = lane_q[DivStages-1];

endmodule
